// File: rtl/twodo_pkg.sv
// shared types, constants and tables of the two-wheel arc odometry block
package twodo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  // magnitude width of the shift-add multiplier operands and its signed product width
  localparam int MW   = 37;
  localparam int PW   = 2 * MW + 1;
  // restoring divider widths
  localparam int NUMW = 64;
  localparam int DENW = 33;
  // cordic datapath width
  localparam int CXW  = 34;

  localparam int CFG_IW = 2;

  localparam logic [63:0] ONE_Q30         = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] TURN_PER_RAD    = 64'd683565276;
  localparam logic [63:0] CORDIC_GAIN_INV = 64'd652032874;

  typedef enum logic [CFG_IW-1:0] {
    REG_DIST_PER_COUNT = 2'd0,
    REG_LEFT_OFFSET    = 2'd1,
    REG_RIGHT_OFFSET   = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_TRACK,
    ST_BAM_M,
    ST_BAM_D,
    ST_PART_M,
    ST_PART_D,
    ST_HALF,
    ST_H,
    ST_S,
    ST_ST,
    ST_SD,
    ST_CHORD,
    ST_COR,
    ST_XM,
    ST_YM,
    ST_DONE
  } state_t;

  // atan(2^-i) as a binary angle, full circle 2^32
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000029;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000003;
      5'd29: r = 30'h00000001;
      5'd30: r = 30'h00000001;
      default: r = 30'h00000000;
    endcase
    return r;
  endfunction

  // horner divisors of the sinc series, innermost first
  function automatic logic [7:0] sinc_div(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0: r = 8'd156;
      3'd1: r = 8'd110;
      3'd2: r = 8'd72;
      3'd3: r = 8'd42;
      3'd4: r = 8'd20;
      3'd5: r = 8'd6;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(PW'(64'sd2147483647))) r = 32'sh7FFFFFFF;
    else if (v < $signed(-PW'(64'sd2147483648))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/twodo_in_if.sv
// encoder sample channel
interface twodo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;

  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

// File: rtl/twodo_out_if.sv
// pose result channel
interface twodo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic        [31:0] heading;

  modport source (output valid, x_pos, y_pos, heading, input ready);
  modport sink (input valid, x_pos, y_pos, heading, output ready);
endinterface

// File: rtl/two_wheel_arc_odometry.sv
// Arc odometry for a two-wheel base. Each item of absolute left and right encoder
// counts updates the pose (X, Y saturated signed Q16.16, heading as a wrapping
// binary angle) and returns it. The work runs through one shared shift-add
// multiplier at one multiplier bit per cycle (up to 15 products), one restoring
// divider at one quotient bit per cycle (up to 8 quotients) and a rotation cordic
// at one step per cycle; the heading and arc split steps are skipped when
// left_offset + right_offset is zero. A new item is taken while the previous pose
// still waits at the output register. Configuration is to be written only while
// the block is idle; the block itself does not enforce this.
module two_wheel_arc_odometry #(
  parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = twodo_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  twodo_in_if.sink                      in,
  twodo_out_if.source                   out,
  input  logic                          cfg_we,
  input  logic [twodo_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data
);
  import twodo_pkg::*;

  localparam logic [63:0] DPC_RST =
    ((64'd1021017612 << FRAC_BITS) + 64'd18000000000) / 64'd36000000000;
  localparam logic [31:0] OFF_RST = 32'(64'd9 << (FRAC_BITS - 1));
  localparam int CCW = $clog2(CORDIC_STEPS);
  localparam int MCW = $clog2(MW);
  localparam int DCW = $clog2(NUMW);
  localparam logic signed [MW-1:0] ONE = MW'(ONE_Q30);

  // configuration
  logic [31:0] dist_per_count, left_offset, right_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count <= DPC_RST[31:0];
      left_offset    <= OFF_RST;
      right_offset   <= OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIST_PER_COUNT: dist_per_count <= cfg_data;
        REG_LEFT_OFFSET:    left_offset    <= cfg_data;
        REG_RIGHT_OFFSET:   right_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DENW-1:0] track;
  assign track = {1'b0, left_offset} + {1'b0, right_offset};

  // sequencer
  state_t state, state_next;
  logic   go, go_next;
  logic   fin;
  logic   mul_start, div_start, cor_start;
  logic signed [MW-1:0] mul_a, mul_b;
  logic [NUMW-1:0] div_num;
  logic [DENW-1:0] div_den;
  logic   out_load;

  // multiplier
  logic            m_run, m_neg;
  logic [MCW-1:0]  m_cnt;
  logic [2*MW-1:0] m_a, m_acc;
  logic [MW-1:0]   m_b;
  logic signed [PW-1:0] prod, prod_pos, prod_sh;

  // divider
  logic            d_run;
  logic [DCW-1:0]  d_cnt;
  logic [NUMW-1:0] d_q;
  logic [DENW-1:0] d_rem, d_den;
  logic [DENW:0]   d_trial;

  // cordic
  logic                  c_run, c_flip;
  logic [CCW-1:0]        c_cnt;
  logic signed [CXW-1:0] c_x, c_y, c_z, c_xs, c_ys, c_at;
  logic [31:0]           c_ang;

  // step datapath
  logic signed [31:0]   prev_left, prev_right, dcl, dcr, dl, dr, dth, half;
  logic signed [31:0]   x_acc, y_acc;
  logic [31:0]          heading_acc;
  logic                 diff_neg, v_neg;
  logic [DENW-1:0]      mag;
  logic signed [MW-1:0] dc, h, s, t, v, chord, sn, cs;
  logic [2:0]           k;
  logic signed [MW-1:0] qs;
  logic [31:0]          half_mag;

  assign fin = go && !m_run && !d_run && !c_run;
  assign in.ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out.valid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
    end
  end

  always_comb begin
    state_t nxt;
    logic   is_op;
    nxt        = state;
    is_op      = 1'b0;
    state_next = state;
    go_next    = go;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    case (state)
      ST_IDLE: if (in.valid) state_next = ST_MUL_L;
      ST_MUL_L: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_MUL_R;
        mul_a = MW'(dcl); mul_b = MW'(dist_per_count);
      end
      ST_MUL_R: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_TRACK;
        mul_a = MW'(dcr); mul_b = MW'(dist_per_count);
      end
      ST_TRACK: state_next = (track == '0) ? ST_HALF : ST_BAM_M;
      ST_BAM_M: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_BAM_D;
        mul_a = MW'(mag); mul_b = MW'(TURN_PER_RAD);
      end
      ST_BAM_D: begin
        is_op = 1'b1; div_start = !go; nxt = ST_PART_M;
        div_num = prod[NUMW-1:0]; div_den = track;
      end
      ST_PART_M: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_PART_D;
        mul_a = MW'(mag); mul_b = MW'(right_offset);
      end
      ST_PART_D: begin
        is_op = 1'b1; div_start = !go; nxt = ST_HALF;
        div_num = prod[NUMW-1:0]; div_den = track;
      end
      ST_HALF: state_next = ST_H;
      ST_H: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_S;
        mul_a = MW'(half_mag); mul_b = MW'(HALF_PI_Q30);
      end
      ST_S: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_ST;
        mul_a = h; mul_b = h;
      end
      ST_ST: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_SD;
        mul_a = s; mul_b = t;
      end
      ST_SD: begin
        is_op = 1'b1; div_start = !go;
        nxt = (k == 3'd5) ? ST_CHORD : ST_ST;
        div_num = NUMW'(v_neg ? -v : v); div_den = DENW'(sinc_div(k));
      end
      ST_CHORD: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_COR;
        mul_a = dc; mul_b = t;
      end
      ST_COR: begin
        is_op = 1'b1; cor_start = !go; nxt = ST_XM;
      end
      ST_XM: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_YM;
        mul_a = chord; mul_b = sn;
      end
      ST_YM: begin
        is_op = 1'b1; mul_start = !go; nxt = ST_DONE;
        mul_a = chord; mul_b = cs;
      end
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (is_op) begin
      if (!go) begin
        go_next = 1'b1;
      end else if (fin) begin
        go_next    = 1'b0;
        state_next = nxt;
      end
    end
  end

  // shift-add multiplier on magnitudes, one multiplier bit per cycle
  assign prod_pos = $signed({1'b0, m_acc});
  assign prod     = m_neg ? -prod_pos : prod_pos;
  assign prod_sh  = prod >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_run <= 1'b0;
    end else if (mul_start) begin
      m_run <= 1'b1;
    end else if (m_run && m_cnt == MCW'(MW - 1)) begin
      m_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      m_a   <= {{MW{1'b0}}, (mul_a[MW-1] ? -mul_a : mul_a)};
      m_b   <= mul_b[MW-1] ? -mul_b : mul_b;
      m_acc <= '0;
      m_neg <= mul_a[MW-1] ^ mul_b[MW-1];
      m_cnt <= '0;
    end else if (m_run) begin
      if (m_b[0]) m_acc <= m_acc + m_a;
      m_a   <= m_a << 1;
      m_b   <= m_b >> 1;
      m_cnt <= m_cnt + MCW'(1);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign d_trial = {d_rem, d_q[NUMW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_run <= 1'b0;
    end else if (div_start) begin
      d_run <= 1'b1;
    end else if (d_run && d_cnt == DCW'(NUMW - 1)) begin
      d_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      d_q   <= div_num;
      d_den <= div_den;
      d_rem <= '0;
      d_cnt <= '0;
    end else if (d_run) begin
      if (d_trial >= {1'b0, d_den}) begin
        d_rem <= DENW'(d_trial - {1'b0, d_den});
        d_q   <= {d_q[NUMW-2:0], 1'b1};
      end else begin
        d_rem <= d_trial[DENW-1:0];
        d_q   <= {d_q[NUMW-2:0], 1'b0};
      end
      d_cnt <= d_cnt + DCW'(1);
    end
  end

  // rotation cordic, one step per cycle
  assign c_ang = heading_acc + half;
  assign c_xs  = c_x >>> c_cnt;
  assign c_ys  = c_y >>> c_cnt;
  assign c_at  = $signed({{(CXW-30){1'b0}}, atan_bam(5'(c_cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_run <= 1'b0;
    end else if (cor_start) begin
      c_run <= 1'b1;
    end else if (c_run && c_cnt == CCW'(CORDIC_STEPS - 1)) begin
      c_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cor_start) begin
      // fold the second and third quadrants by a half turn
      c_flip <= c_ang[31] ^ c_ang[30];
      c_z    <= CXW'($signed({c_ang[30], c_ang[30:0]}));
      c_x    <= CXW'(CORDIC_GAIN_INV);
      c_y    <= '0;
      c_cnt  <= '0;
    end else if (c_run) begin
      if (!c_z[CXW-1]) begin
        c_x <= c_x - c_ys;
        c_y <= c_y + c_xs;
        c_z <= c_z - c_at;
      end else begin
        c_x <= c_x + c_ys;
        c_y <= c_y - c_xs;
        c_z <= c_z + c_at;
      end
      c_cnt <= c_cnt + CCW'(1);
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= '0;
      prev_right  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      if (in.valid && in.ready) begin
        prev_left  <= in.left_count;
        prev_right <= in.right_count;
      end
      if (fin && state == ST_XM) x_acc <= sat32(PW'(x_acc) + prod_sh);
      if (fin && state == ST_YM) y_acc <= sat32(PW'(y_acc) + prod_sh);
      if (out_load) heading_acc <= heading_acc + dth;
    end
  end

  assign qs       = $signed(d_q[MW-1:0]);
  assign half_mag = half[31] ? -half : half;

  // step datapath
  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      dcl <= in.left_count - prev_left;
      dcr <= in.right_count - prev_right;
    end
    case (state)
      ST_MUL_L: if (fin) dl <= sat32(prod);
      ST_MUL_R: if (fin) dr <= sat32(prod);
      ST_TRACK: begin
        diff_neg <= (dl < dr);
        mag      <= (dl < dr) ? DENW'((DENW+1)'(dr) - (DENW+1)'(dl))
                              : DENW'((DENW+1)'(dl) - (DENW+1)'(dr));
        dth      <= '0;
        dc       <= MW'(dl);
      end
      ST_BAM_D: if (fin) begin
        if (d_q > 64'h7FFFFFFF) dth <= diff_neg ? -32'sh7FFFFFFF : 32'sh7FFFFFFF;
        else dth <= diff_neg ? -$signed(d_q[31:0]) : $signed(d_q[31:0]);
      end
      ST_PART_D: if (fin) begin
        dc <= diff_neg ? MW'(dr) - $signed(MW'(d_q[DENW-1:0]))
                       : MW'(dr) + $signed(MW'(d_q[DENW-1:0]));
      end
      // division by two toward zero
      ST_HALF: half <= $signed(dth + {31'b0, dth[31]}) >>> 1;
      ST_H: if (fin) h <= MW'(prod_sh);
      ST_S: if (fin) begin
        s <= MW'(prod_sh);
        t <= ONE;
        k <= '0;
      end
      ST_ST: if (fin) begin
        v     <= MW'(prod_sh);
        v_neg <= prod_sh[PW-1];
      end
      ST_SD: if (fin) begin
        t <= v_neg ? ONE + qs : ONE - qs;
        k <= k + 3'd1;
      end
      ST_CHORD: if (fin) chord <= MW'(prod_sh);
      ST_COR: if (fin) begin
        sn <= MW'(c_flip ? -c_y : c_y);
        cs <= MW'(c_flip ? -c_x : c_x);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (out_load) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out.x_pos   <= x_acc;
      out.y_pos   <= y_acc;
      out.heading <= heading_acc + dth;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after taking an item");

  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DONE) |=> $stable(heading_acc))
    else $error("heading moved outside result hand-off");

  a_div_track: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_BAM_D || state == ST_PART_D) && !go) |-> (track != '0))
    else $error("divide by zero track");

endmodule

// File: verif/two_wheel_arc_odometry_tb.sv
// testbench of the two-wheel arc odometry block: random and directed encoder samples
`timescale 1ns / 1ps

module two_wheel_arc_odometry_tb;
  import twodo_pkg::*;

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint Q30_HPI    = 64'sd1686629713;
  localparam longint unsigned BAM_PER_RAD = 64'd683565276;
  localparam longint Q30_KINV   = 64'sd652032874;
  localparam int     ROT_STEPS  = CORDIC_STEPS_DEF;
  localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;
  localparam int     ITEM_CYCLES = 1200;
  localparam longint CYCLE_LIMIT = 64'd9000000;
  localparam int     HOLD_CYCLES = 4000;

  localparam longint ATAN_TURN [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };
  localparam longint SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] hd;
  } pose_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0] cfg_data;

  twodo_in_if  in_ch ();
  twodo_out_if out_ch ();

  two_wheel_arc_odometry dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and settings
  logic [31:0] scale_q, left_arm, right_arm;
  logic [31:0] last_left, last_right, head_est;
  longint      x_est, y_est;
  pose_t       pose_q[$];

  logic [31:0] sent_left, sent_right;
  int  mismatches = 0;
  int  items_sent = 0;
  int  poses_seen = 0;
  longint cycles = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sinc_of_half(input longint half);
    longint mag, h, s, t;
    mag = half < 0 ? -half : half;
    h = (mag * Q30_HPI) >>> 30;
    s = (h * h) >>> 30;
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) t = Q30_ONE - ((s * t) >>> 30) / SERIES_DIV[k];
    return t;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint sn, output longint cs);
    bit flip;
    longint x, y, z, t;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    x = Q30_KINV;
    y = 0;
    if (flip) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_TURN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_TURN[i];
      end
      x = t;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  task automatic predict_pose(input logic [31:0] cl, input logic [31:0] cr);
    logic [31:0] dcl, dcr, mid;
    longint dl, dr, diff, dth, dc, half, chord, sn, cs;
    longint unsigned trk, mag, bam, part;
    pose_t p;
    dcl = cl - last_left;
    dcr = cr - last_right;
    dl = clamp32(longint'($signed(dcl)) * longint'(scale_q));
    dr = clamp32(longint'($signed(dcr)) * longint'(scale_q));
    trk = longint'(left_arm) + longint'(right_arm);
    diff = dl - dr;
    dth = 0;
    dc = dl;
    mag = diff < 0 ? -diff : diff;
    if (trk != 0) begin
      bam = mag * BAM_PER_RAD / trk;
      part = mag * longint'(right_arm) / trk;
      if (bam > 64'h7FFFFFFF) bam = 64'h7FFFFFFF;
      dth = diff < 0 ? -longint'(bam) : longint'(bam);
      dc = dr + (diff < 0 ? -longint'(part) : longint'(part));
    end
    half = dth / 2;
    chord = (dc * sinc_of_half(half)) >>> 30;
    mid = head_est + half[31:0];
    rotate(mid, sn, cs);
    x_est = clamp32(x_est + ((chord * sn) >>> 30));
    y_est = clamp32(y_est + ((chord * cs) >>> 30));
    head_est = head_est + dth[31:0];
    last_left = cl;
    last_right = cr;
    p.x = x_est[31:0];
    p.y = y_est[31:0];
    p.hd = head_est;
    pose_q.push_back(p);
  endtask

  task automatic send_sample(input logic [31:0] cl, input logic [31:0] cr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_count <= cl;
    in_ch.right_count <= cr;
    do @(posedge clk); while (!in_ch.ready);
    predict_pose(cl, cr);
    sent_left = cl;
    sent_right = cr;
    items_sent++;
  endtask

  // lower valid, let every pose come back and the block go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (ITEM_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] scale, input logic [31:0] la,
                            input logic [31:0] ra);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_DIST_PER_COUNT;
    cfg_data <= scale;
    @(posedge clk);
    cfg_index <= REG_LEFT_OFFSET;
    cfg_data <= la;
    @(posedge clk);
    cfg_index <= REG_RIGHT_OFFSET;
    cfg_data <= ra;
    @(posedge clk);
    // unused index must leave everything alone
    cfg_index <= REG_NONE;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    scale_q = scale;
    left_arm = la;
    right_arm = ra;
  endtask

  // next sample: mostly small wheel motion from the last counts, some straight runs,
  // some turns in place, some jumps and full random counts
  task automatic random_sample();
    int sel;
    int dl, dr;
    sel = $urandom_range(0, 99);
    dl = $urandom_range(0, 4000) - 2000;
    dr = $urandom_range(0, 4000) - 2000;
    if (sel < 55) send_sample(sent_left + dl, sent_right + dr);
    else if (sel < 70) send_sample(sent_left + dl, sent_right + dl);
    else if (sel < 80) send_sample(sent_left + dl, sent_right - dl);
    else if (sel < 90) send_sample(sent_left + $urandom_range(0, 1 << 24) - (1 << 23),
                                   sent_right + $urandom_range(0, 1 << 24) - (1 << 23));
    else send_sample($urandom, $urandom);
  endtask

  task automatic test_directed();
    send_sample(32'd0, 32'd0);
    send_sample(32'd500, 32'd500);
    send_sample(32'd1000, 32'd0);
    send_sample(32'd0, 32'd1000);
    send_sample(32'd400, 32'd800);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    // encoder wrap gives a small true step
    send_sample(32'h7FFFFFF0, 32'h7FFFFFF0);
    send_sample(32'h80000010, 32'h80000008);
    send_sample(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_sample(32'h00000005, 32'h00000002);
    send_sample(32'hFFFFFFFF, 32'h00000000);
    send_sample(32'h00000000, 32'hFFFFFFFF);
    send_sample(32'h55555555, 32'hAAAAAAAA);
    send_sample(32'hAAAAAAAA, 32'h55555555);
  endtask

  task automatic test_zero_track();
    set_config(32'd1859, 32'd0, 32'd0);
    send_sample(sent_left + 1000, sent_right + 200);
    send_sample(sent_left - 3000, sent_right + 900);
    repeat (40) random_sample();
  endtask

  task automatic test_extreme_config();
    set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    repeat (40) random_sample();
    set_config(32'd0, 32'd1, 32'hFFFFFFFF);
    repeat (20) random_sample();
    // large scale drives the pose into saturation
    set_config(32'hFFFFFFFF, 32'd65536, 32'd0);
    send_sample(sent_left + 32'h40000000, sent_right + 32'h40000000);
    repeat (40) random_sample();
  endtask

  task automatic test_backpressure();
    set_config(32'd1859, 32'd294912, 32'd294912);
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (8) random_sample();
    steady = 1'b0;
  endtask

  task automatic test_random();
    set_config(32'd1859, 32'd294912, 32'd294912);
    repeat (500) random_sample();
    steady = 1'b1;
    repeat (150) random_sample();
    steady = 1'b0;
    set_config($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 22),
               $urandom_range(1, 1 << 22));
    repeat (350) random_sample();
    set_config($urandom, $urandom, $urandom);
    repeat (200) random_sample();
    set_config($urandom_range(1, 1 << 18), $urandom_range(0, 1 << 20), 32'd0);
    repeat (150) random_sample();
  endtask

  // pose checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      poses_seen++;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h heading=%h", $time,
                 out_ch.x_pos, out_ch.y_pos, out_ch.heading);
        mismatches++;
      end else begin
        pose_t e;
        e = pose_q.pop_front();
        if (out_ch.x_pos !== e.x) begin
          $display("%0t: x_pos expected %h actual %h", $time, e.x, out_ch.x_pos);
          mismatches++;
        end
        if (out_ch.y_pos !== e.y) begin
          $display("%0t: y_pos expected %h actual %h", $time, e.y, out_ch.y_pos);
          mismatches++;
        end
        if (out_ch.heading !== e.hd) begin
          $display("%0t: heading expected %h actual %h", $time, e.hd, out_ch.heading);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold when asked
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid && !hold_req);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DIST_PER_COUNT;
    cfg_data = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.left_count = 32'd0;
    in_ch.right_count = 32'd0;
    scale_q = 32'd1859;
    left_arm = 32'd294912;
    right_arm = 32'd294912;
    last_left = 32'd0;
    last_right = 32'd0;
    head_est = 32'd0;
    x_est = 0;
    y_est = 0;
    sent_left = 32'd0;
    sent_right = 32'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_track();
    test_extreme_config();
    test_backpressure();
    test_random();
    settle();
    $display("sent %0d encoder samples over default, zero-track, extreme and random settings",
             items_sent);
    $display("checked %0d poses, %0d field mismatches", poses_seen, mismatches);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
